### hw/rtl/line_segment_screen_clipper_core_assert.svh
// ----------------------------------------------------------------------------
// line segment screen clipper assertion macros
// shared property forms for the clipper checks
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_SCREEN_CLIPPER_CORE_ASSERT_SVH
`define LINE_SEGMENT_SCREEN_CLIPPER_CORE_ASSERT_SVH

// same-cycle implication
`define LSSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/lssc_pkg.sv
// ----------------------------------------------------------------------------
// line segment screen clipper package
// widths, codes and pipeline records shared by the clipper modules
// ----------------------------------------------------------------------------
`default_nettype none

package lssc_pkg;

	localparam int CW  = 32;
	localparam int MW  = 32;
	localparam int PW  = 2 * MW;
	localparam int QW  = 34;
	localparam int DIM = 15;

	localparam logic [DIM-1:0] WIDTH_RST  = 15'd640;
	localparam logic [DIM-1:0] HEIGHT_RST = 15'd480;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam int EDGE_WEST  = 0;
	localparam int EDGE_EAST  = 1;
	localparam int EDGE_SOUTH = 2;
	localparam int EDGE_NORTH = 3;
	localparam int NEDGE      = 4;

	typedef logic [CW-1:0] coord_t;

	typedef struct packed {
		logic [MW-1:0] rem;
		logic [QW-1:0] low;
		logic [QW-1:0] quo;
		logic [MW-1:0] den;
		logic          ovf;
	} div_st_t;

	typedef struct packed {
		logic             general;
		logic             ok;
		coord_t           x1;
		coord_t           y1;
		coord_t           x2;
		coord_t           y2;
		logic             i1;
		logic             i2;
		logic [NEDGE-1:0] neg;
	} ctx_t;

endpackage

`default_nettype wire

### hw/rtl/lssc_if.sv
// ----------------------------------------------------------------------------
// line segment screen clipper channels
// segment input channel and clipped result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface lssc_seg_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lssc_res_if;
	logic               valid;
	logic               ready;
	logic               rejected;
	logic signed [31:0] clip_start_x;
	logic signed [31:0] clip_start_y;
	logic signed [31:0] clip_end_x;
	logic signed [31:0] clip_end_y;
	modport source (output valid, rejected, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, input ready);
	modport sink (input valid, rejected, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, output ready);
endinterface

`default_nettype wire

### hw/rtl/line_segment_screen_clipper_core.sv
// path: stage 1, stage 2, the edge divider stages, stage a and the result register
// throughput: one segment per cycle unless the result stalls, set by the 34-stage pipelined edge dividers
// a stalled result holds the whole pipeline in place
// reset: asynchronous active low, clears valid bits and sets the screen to 640 x 480
// ----------------------------------------------------------------------------
// line segment screen clipper core
// clips one segment per cycle, while the result is not stalled, to the configured raster
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_screen_clipper_core
	import lssc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	lssc_seg_if.sink         seg_in,
	lssc_res_if.source       res_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	`include "line_segment_screen_clipper_core_assert.svh"

	logic [DIM-1:0] scr_w;
	logic [DIM-1:0] scr_h;
	logic           en;

	lssc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.scr_w   (scr_w),
		.scr_h   (scr_h)
	);

	assign pready = 1'b1;

	assign en           = !res_out.valid | res_out.ready;
	assign seg_in.ready = en;

	function automatic logic [MW-1:0] mag34(input logic [33:0] v);
		logic [33:0] n;
		n = -v;
		return v[33] ? n[MW-1:0] : v[MW-1:0];
	endfunction

	// stage 1: classify, clamp the axis-aligned cases, edge operands
	coord_t sx, sy, ex, ey;
	logic [30:0] wl, hl;
	logic in1, in2, out_y_lo, out_y_hi, out_x_lo, out_x_hi, triv;
	logic [33:0] dx, dy, bw, be, bs, bn;
	coord_t wm1, hm1;
	ctx_t ctx_c;

	assign sx  = seg_in.start_x;
	assign sy  = seg_in.start_y;
	assign ex  = seg_in.end_x;
	assign ey  = seg_in.end_y;
	assign wl  = {{(31-DIM){1'b0}}, scr_w};
	assign hl  = {{(31-DIM){1'b0}}, scr_h};
	assign wm1 = {{(CW-DIM){1'b0}}, scr_w} - 32'd1;
	assign hm1 = {{(CW-DIM){1'b0}}, scr_h} - 32'd1;

	assign in1 = !sx[31] && sx[30:0] < wl && !sy[31] && sy[30:0] < hl;
	assign in2 = !ex[31] && ex[30:0] < wl && !ey[31] && ey[30:0] < hl;
	assign out_y_lo = sy[31] && ey[31];
	assign out_y_hi = !sy[31] && sy[30:0] >= hl && !ey[31] && ey[30:0] >= hl;
	assign out_x_lo = sx[31] && ex[31];
	assign out_x_hi = !sx[31] && sx[30:0] >= wl && !ex[31] && ex[30:0] >= wl;
	assign triv = !in1 && !in2 && (out_y_lo || out_y_hi || out_x_lo || out_x_hi);

	assign dx = {{2{ex[31]}}, ex} - {{2{sx[31]}}, sx};
	assign dy = {{2{ey[31]}}, ey} - {{2{sy[31]}}, sy};
	assign bw = -{{2{sx[31]}}, sx};
	assign be = {{(34-DIM){1'b0}}, scr_w} - 34'd1 - {{2{sx[31]}}, sx};
	assign bs = -{{2{sy[31]}}, sy};
	assign bn = {{(34-DIM){1'b0}}, scr_h} - 34'd1 - {{2{sy[31]}}, sy};

	always_comb begin
		ctx_c.general = 1'b0;
		ctx_c.ok      = 1'b1;
		ctx_c.x1      = sx;
		ctx_c.y1      = sy;
		ctx_c.x2      = ex;
		ctx_c.y2      = ey;
		ctx_c.i1      = in1;
		ctx_c.i2      = in2;
		ctx_c.neg[EDGE_WEST]  = dy[33] ^ bw[33] ^ dx[33];
		ctx_c.neg[EDGE_EAST]  = dy[33] ^ be[33] ^ dx[33];
		ctx_c.neg[EDGE_SOUTH] = dx[33] ^ bs[33] ^ dy[33];
		ctx_c.neg[EDGE_NORTH] = dx[33] ^ bn[33] ^ dy[33];
		priority if (in1 && in2) begin
			ctx_c.ok = 1'b1;
		end else if (triv) begin
			ctx_c.ok = 1'b0;
		end else if (sx == ex) begin
			if (sx[31] || sx[30:0] >= wl) begin
				ctx_c.ok = 1'b0;
			end else if ($signed(ey) > $signed(sy)) begin
				if (!in1) ctx_c.y1 = '0;
				if (!in2) ctx_c.y2 = hm1;
			end else begin
				if (!in1) ctx_c.y1 = hm1;
				if (!in2) ctx_c.y2 = '0;
			end
		end else if (sy == ey) begin
			if (sy[31] || sy[30:0] >= hl) begin
				ctx_c.ok = 1'b0;
			end else if ($signed(ex) > $signed(sx)) begin
				if (!in1) ctx_c.x1 = '0;
				if (!in2) ctx_c.x2 = wm1;
			end else begin
				if (!in1) ctx_c.x1 = wm1;
				if (!in2) ctx_c.x2 = '0;
			end
		end else begin
			ctx_c.general = 1'b1;
		end
	end

	logic    v_s1;
	ctx_t    ctx_s1;
	logic [MW-1:0] mdx_s1, mdy_s1, mbw_s1, mbe_s1, mbs_s1, mbn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= seg_in.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_c;
			mdx_s1 <= mag34(dx);
			mdy_s1 <= mag34(dy);
			mbw_s1 <= mag34(bw);
			mbe_s1 <= mag34(be);
			mbs_s1 <= mag34(bs);
			mbn_s1 <= mag34(bn);
		end
	end

	// stage 2: scaled products
	logic    v_s2;
	ctx_t    ctx_s2;
	logic [PW-1:0] prod_s2 [NEDGE];
	logic [MW-1:0] den_s2 [NEDGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx_s1;
			prod_s2[EDGE_WEST]  <= mdy_s1 * mbw_s1;
			prod_s2[EDGE_EAST]  <= mdy_s1 * mbe_s1;
			prod_s2[EDGE_SOUTH] <= mdx_s1 * mbs_s1;
			prod_s2[EDGE_NORTH] <= mdx_s1 * mbn_s1;
			den_s2[EDGE_WEST]   <= mdx_s1;
			den_s2[EDGE_EAST]   <= mdx_s1;
			den_s2[EDGE_SOUTH]  <= mdy_s1;
			den_s2[EDGE_NORTH]  <= mdy_s1;
		end
	end

	// divider stages, context travels alongside
	logic [QW-1:0] quo_d [NEDGE];
	logic [NEDGE-1:0] ovf_d;

	for (genvar e = 0; e < NEDGE; e++) begin : g_div
		lssc_div u_div (
			.clk  (clk),
			.en   (en),
			.prod (prod_s2[e]),
			.den  (den_s2[e]),
			.quo  (quo_d[e]),
			.ovf  (ovf_d[e])
		);
	end

	logic [QW-1:0] v_d;
	ctx_t          ctx_d [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_d <= '0;
		else if (en) v_d <= {v_d[QW-2:0], v_s2};
	end

	always_ff @(posedge clk) begin
		if (en) ctx_d[0] <= ctx_s2;
	end

	for (genvar k = 1; k < QW; k++) begin : g_ctx
		always_ff @(posedge clk) begin
			if (en) ctx_d[k] <= ctx_d[k-1];
		end
	end

	// stage a: edge hits
	ctx_t ctx_l;
	logic [35:0] iv [NEDGE];
	logic [NEDGE-1:0] hit_c;

	assign ctx_l = ctx_d[QW-1];

	for (genvar e = 0; e < NEDGE; e++) begin : g_hit
		logic [35:0] base;
		logic [35:0] qx;
		logic [34:0] lim;
		assign base = (e == EDGE_WEST || e == EDGE_EAST) ?
			{{4{ctx_l.y1[31]}}, ctx_l.y1} : {{4{ctx_l.x1[31]}}, ctx_l.x1};
		assign lim = (e == EDGE_WEST || e == EDGE_EAST) ?
			{{(35-DIM){1'b0}}, scr_h} : {{(35-DIM){1'b0}}, scr_w};
		assign qx = {2'b0, quo_d[e]};
		assign iv[e] = base + (ctx_l.neg[e] ? -qx : qx);
		assign hit_c[e] = !ovf_d[e] && !iv[e][35] && iv[e][34:0] < lim;
	end

	logic             v_sa;
	ctx_t             ctx_sa;
	logic [NEDGE-1:0] hit_sa;
	logic [NEDGE-1:0] ovf_sa;
	coord_t           iv_sa [NEDGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sa <= 1'b0;
		else if (en) v_sa <= v_d[QW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_sa <= ctx_l;
			hit_sa <= hit_c;
			ovf_sa <= ovf_d;
			for (int e = 0; e < NEDGE; e++) iv_sa[e] <= iv[e][CW-1:0];
		end
	end

	// stage b: pick endpoints from the hits
	coord_t hx [NEDGE];
	coord_t hy [NEDGE];
	coord_t h0x, h0y, h1x, h1y;
	logic [2:0] cnt;
	logic   ok_f, pk_ok, pk1;
	coord_t ax, ay, bx, by, rx1, ry1, rx2, ry2;

	always_comb begin
		hx[EDGE_WEST]  = '0;
		hy[EDGE_WEST]  = iv_sa[EDGE_WEST];
		hx[EDGE_EAST]  = {{(CW-DIM){1'b0}}, scr_w} - 32'd1;
		hy[EDGE_EAST]  = iv_sa[EDGE_EAST];
		hx[EDGE_SOUTH] = iv_sa[EDGE_SOUTH];
		hy[EDGE_SOUTH] = '0;
		hx[EDGE_NORTH] = iv_sa[EDGE_NORTH];
		hy[EDGE_NORTH] = {{(CW-DIM){1'b0}}, scr_h} - 32'd1;
		h0x = '0;
		h0y = '0;
		h1x = '0;
		h1y = '0;
		cnt = '0;
		for (int e = 0; e < NEDGE; e++) begin
			if (hit_sa[e]) begin
				if (cnt == 3'd0) begin
					h0x = hx[e];
					h0y = hy[e];
				end else begin
					h1x = hx[e];
					h1y = hy[e];
				end
				cnt = cnt + 3'd1;
			end
		end

		ax = ctx_sa.i2 ? ctx_sa.x2 : ctx_sa.x1;
		ay = ctx_sa.i2 ? ctx_sa.y2 : ctx_sa.y1;
		bx = ctx_sa.i2 ? ctx_sa.x1 : ctx_sa.x2;
		by = ctx_sa.i2 ? ctx_sa.y1 : ctx_sa.y2;
		pk_ok = 1'b0;
		pk1   = 1'b0;
		if ($signed(bx) > $signed(ax)) begin
			if ($signed(h1x) >= $signed(ax)) begin
				pk_ok = 1'b1;
				pk1   = 1'b1;
			end else if ($signed(h0x) >= $signed(ax)) begin
				pk_ok = 1'b1;
			end
		end
		if (!pk_ok && $signed(bx) < $signed(ax)) begin
			if ($signed(h1x) <= $signed(ax)) begin
				pk_ok = 1'b1;
				pk1   = 1'b1;
			end else if ($signed(h0x) <= $signed(ax)) begin
				pk_ok = 1'b1;
			end
		end
		if (!pk_ok && $signed(by) > $signed(ay)) begin
			if ($signed(h1y) >= $signed(ay)) begin
				pk_ok = 1'b1;
				pk1   = 1'b1;
			end else if ($signed(h0y) >= $signed(ay)) begin
				pk_ok = 1'b1;
			end
		end
		if (!pk_ok && $signed(by) < $signed(ay)) begin
			if ($signed(h1y) <= $signed(ay)) begin
				pk_ok = 1'b1;
				pk1   = 1'b1;
			end else if ($signed(h0y) <= $signed(ay)) begin
				pk_ok = 1'b1;
			end
		end

		ok_f = ctx_sa.ok;
		rx1  = ctx_sa.x1;
		ry1  = ctx_sa.y1;
		rx2  = ctx_sa.x2;
		ry2  = ctx_sa.y2;
		if (ctx_sa.general) begin
			priority if (cnt == 3'd0) begin
				ok_f = 1'b0;
			end else if (cnt == 3'd1) begin
				rx1 = ctx_sa.x2;
				ry1 = ctx_sa.y2;
			end else if (!ctx_sa.i1 && !ctx_sa.i2) begin
				rx1 = h0x;
				ry1 = h0y;
				rx2 = h1x;
				ry2 = h1y;
			end else begin
				ok_f = pk_ok;
				rx1  = ax;
				ry1  = ay;
				rx2  = pk1 ? h1x : h0x;
				ry2  = pk1 ? h1y : h0y;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_out.valid <= 1'b0;
		else if (en) res_out.valid <= v_sa;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_out.rejected     <= !ok_f;
			res_out.clip_start_x <= ok_f ? rx1 : '0;
			res_out.clip_start_y <= ok_f ? ry1 : '0;
			res_out.clip_end_x   <= ok_f ? rx2 : '0;
			res_out.clip_end_y   <= ok_f ? ry2 : '0;
		end
	end

	`LSSC_ASSERT_NOW(a_rej_zero, res_out.valid && res_out.rejected,
		res_out.clip_start_x == 0 && res_out.clip_start_y == 0 &&
		res_out.clip_end_x == 0 && res_out.clip_end_y == 0,
		"rejected result with nonzero coordinates")
	`LSSC_ASSERT_NOW(a_stall_back, res_out.valid && !res_out.ready, !seg_in.ready,
		"input taken while result stalled")
	`LSSC_ASSERT_NOW(a_ovf_nohit, v_sa && ovf_sa != 0, (hit_sa & ovf_sa) == 0,
		"edge hit from an overflowed quotient")

endmodule

`default_nettype wire

### hw/rtl/lssc_div.sv
// ----------------------------------------------------------------------------
// line segment screen clipper divider
// pipelined restoring divider, one quotient bit per stage, overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_div
	import lssc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [PW-1:0] prod,
	input  wire logic [MW-1:0] den,
	output      logic [QW-1:0] quo,
	output      logic          ovf
);

	div_st_t st [QW+1];

	// high part at or above the divisor means the quotient does not fit
	always_comb begin
		st[0].ovf = {{(MW-(PW-QW)){1'b0}}, prod[PW-1:QW]} >= den;
		st[0].rem = {{(MW-(PW-QW)){1'b0}}, prod[PW-1:QW]};
		st[0].low = prod[QW-1:0];
		st[0].quo = '0;
		st[0].den = den;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [MW:0] trial;
		logic        ge;
		assign trial = {st[k].rem, st[k].low[QW-1]};
		assign ge    = trial >= {1'b0, st[k].den};
		always_ff @(posedge clk) begin
			if (en) begin
				st[k+1].rem <= ge ? MW'(trial - {1'b0, st[k].den}) : trial[MW-1:0];
				st[k+1].low <= {st[k].low[QW-2:0], 1'b0};
				st[k+1].quo <= {st[k].quo[QW-2:0], ge};
				st[k+1].den <= st[k].den;
				st[k+1].ovf <= st[k].ovf;
			end
		end
	end

	assign quo = st[QW].quo;
	assign ovf = st[QW].ovf;

endmodule

`default_nettype wire

### hw/rtl/lssc_cfg.sv
// ----------------------------------------------------------------------------
// line segment screen clipper configuration registers
// apb write and read of the screen width and height
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_cfg
	import lssc_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [2:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output      logic [31:0]    prdata,
	output      logic [DIM-1:0] scr_w,
	output      logic [DIM-1:0] scr_h
);

	logic wr;
	logic [DIM-1:0] width_q;
	logic [DIM-1:0] height_q;

	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[DIM-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM-1:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = {{(32-DIM){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-DIM){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	assign scr_w = width_q;
	assign scr_h = height_q;

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line segment screen clipper testbench
// drives segments, with random gaps outside the no-idle phase, predicts each clipped result and compares
// it field by field; screen size is reprogrammed between phases
// ----------------------------------------------------------------------------
`default_nettype none

module tb
	import lssc_pkg::*;
();

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
	} seg_t;

	typedef struct packed {
		logic               rej;
		logic signed [31:0] csx;
		logic signed [31:0] csy;
		logic signed [31:0] cex;
		logic signed [31:0] cey;
	} clip_t;

	localparam int LATENCY = 37;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	lssc_seg_if seg_in ();
	lssc_res_if res_out ();

	logic [14:0] scr_w = WIDTH_RST;
	logic [14:0] scr_h = HEIGHT_RST;
	clip_t       clip_q[$];
	int          fails = 0;
	bit          no_idle = 1'b0;
	int          sink_hold = 0;

	line_segment_screen_clipper_core u_dut (
		.clk(clk), .arst_n(arst_n), .seg_in(seg_in.sink), .res_out(res_out.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		seg_in.valid = 1'b0;
		seg_in.start_x = '0;
		seg_in.start_y = '0;
		seg_in.end_x = '0;
		seg_in.end_y = '0;
		res_out.ready = 1'b0;
	end

	// trunc(a*b/d), saturated to 2^40
	function automatic longint hit_offset(longint a, longint b, longint d);
		bit          neg;
		logic [63:0] q;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] md;
		if (d == 0) return 0;
		neg = (a < 0) != (b < 0);
		if (d < 0) neg = !neg;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		md = d < 0 ? -d : d;
		q = (ma * mb) / md;
		if (q > 64'h100_0000_0000) q = 64'h100_0000_0000;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic bit on_raster(longint x, longint y, longint w, longint h);
		return x >= 0 && x < w && y >= 0 && y < h;
	endfunction

	function automatic clip_t clip_segment(seg_t s);
		longint x1, y1, x2, y2, w, h, iv, tmp;
		longint hx[2];
		longint hy[2];
		int     hits, pick, k;
		bit     i1, i2, ok;
		clip_t  r;
		x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
		w = scr_w; h = scr_h;
		hx[0] = 0; hx[1] = 0; hy[0] = 0; hy[1] = 0;
		hits = 0; ok = 1'b1;
		i1 = on_raster(x1, y1, w, h);
		i2 = on_raster(x2, y2, w, h);
		if (i1 && i2) begin
			ok = 1'b1;
		end else if (!i1 && !i2 && ((y1 < 0 && y2 < 0) || (y1 >= h && y2 >= h) ||
				(x1 < 0 && x2 < 0) || (x1 >= w && x2 >= w))) begin
			ok = 1'b0;
		end else if (x1 == x2) begin
			if (x1 < 0 || x1 >= w) begin
				ok = 1'b0;
			end else if (y2 > y1) begin
				if (!i1) y1 = 0;
				if (!i2) y2 = h - 1;
			end else begin
				if (!i1) y1 = h - 1;
				if (!i2) y2 = 0;
			end
		end else if (y1 == y2) begin
			if (y1 < 0 || y1 >= h) begin
				ok = 1'b0;
			end else if (x2 > x1) begin
				if (!i1) x1 = 0;
				if (!i2) x2 = w - 1;
			end else begin
				if (!i1) x1 = w - 1;
				if (!i2) x2 = 0;
			end
		end else begin
			iv = y1 + hit_offset(y2 - y1, -x1, x2 - x1);
			if (iv >= 0 && iv < h) begin
				k = hits ? 1 : 0; hx[k] = 0; hy[k] = iv; hits++;
			end
			iv = y1 + hit_offset(y2 - y1, w - 1 - x1, x2 - x1);
			if (iv >= 0 && iv < h) begin
				k = hits ? 1 : 0; hx[k] = w - 1; hy[k] = iv; hits++;
			end
			iv = x1 + hit_offset(x2 - x1, -y1, y2 - y1);
			if (iv >= 0 && iv < w) begin
				k = hits ? 1 : 0; hx[k] = iv; hy[k] = 0; hits++;
			end
			iv = x1 + hit_offset(x2 - x1, h - 1 - y1, y2 - y1);
			if (iv >= 0 && iv < w) begin
				k = hits ? 1 : 0; hx[k] = iv; hy[k] = h - 1; hits++;
			end
			if (hits == 0) begin
				ok = 1'b0;
			end else if (hits == 1) begin
				x1 = x2; y1 = y2;
			end else if (!i1 && !i2) begin
				x1 = hx[0]; y1 = hy[0]; x2 = hx[1]; y2 = hy[1];
			end else begin
				pick = -1;
				if (i2) begin
					tmp = x1; x1 = x2; x2 = tmp;
					tmp = y1; y1 = y2; y2 = tmp;
				end
				if (x2 > x1) begin
					if (hx[1] >= x1) pick = 1;
					else if (hx[0] >= x1) pick = 0;
				end
				if (pick < 0 && x2 < x1) begin
					if (hx[1] <= x1) pick = 1;
					else if (hx[0] <= x1) pick = 0;
				end
				if (pick < 0 && y2 > y1) begin
					if (hy[1] >= y1) pick = 1;
					else if (hy[0] >= y1) pick = 0;
				end
				if (pick < 0 && y2 < y1) begin
					if (hy[1] <= y1) pick = 1;
					else if (hy[0] <= y1) pick = 0;
				end
				if (pick < 0) begin
					ok = 1'b0;
				end else begin
					x2 = hx[pick]; y2 = hy[pick];
				end
			end
		end
		if (!ok) begin
			r = '0;
			r.rej = 1'b1;
		end else begin
			r.rej = 1'b0;
			r.csx = x1[31:0]; r.csy = y1[31:0];
			r.cex = x2[31:0]; r.cey = y2[31:0];
		end
		return r;
	endfunction

	task automatic send_segment(seg_t s);
		int gap;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			seg_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg_in.valid <= 1'b1;
		seg_in.start_x <= s.sx;
		seg_in.start_y <= s.sy;
		seg_in.end_x <= s.ex;
		seg_in.end_y <= s.ey;
		@(posedge clk);
		while (!seg_in.ready) @(posedge clk);
		clip_q.push_back(clip_segment(s));
	endtask

	task automatic end_burst();
		seg_in.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		end_burst();
		while (clip_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr[2] == REG_WIDTH) scr_w = data[14:0];
		else scr_h = data[14:0];
	endtask

	task automatic set_screen(logic [14:0] w, logic [14:0] h);
		drain();
		write_reg(3'(int'(REG_WIDTH) * 4), {17'd0, w});
		write_reg(3'(int'(REG_HEIGHT) * 4), {17'd0, h});
	endtask

	function automatic logic signed [31:0] near_coord(logic [14:0] lim);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return -$signed(32'($urandom_range(1, 4)));
			2: return 32'(lim) + 32'($urandom_range(0, 3)) - 32'sd1;
			3: return 32'sh7fff_ffff - 32'($urandom_range(0, 3));
			4: return 32'sh8000_0000 + 32'($urandom_range(0, 3));
			default: return 32'(int'($urandom_range(0, 3 * lim + 2)) - int'(lim));
		endcase
	endfunction

	function automatic seg_t rand_segment();
		seg_t s;
		s.sx = near_coord(scr_w); s.sy = near_coord(scr_h);
		s.ex = near_coord(scr_w); s.ey = near_coord(scr_h);
		case ($urandom_range(0, 7))
			0: s.ex = s.sx;
			1: s.ey = s.sy;
			default: ;
		endcase
		return s;
	endfunction

	task automatic test_directed();
		seg_t d[$];
		logic signed [31:0] mx, mn, w1, h1;
		mx = 32'sh7fff_ffff; mn = 32'sh8000_0000;
		w1 = 32'(scr_w) - 1; h1 = 32'(scr_h) - 1;
		d.push_back('{10, 20, 300, 400});
		d.push_back('{0, 0, w1, h1});
		d.push_back('{-5, -10, -20, 100});
		d.push_back('{100, -5, 200, -1});
		d.push_back('{w1 + 1, 10, w1 + 50, 300});
		d.push_back('{10, h1 + 1, 20, h1 + 9});
		d.push_back('{50, -100, 50, 900});
		d.push_back('{50, 900, 50, -100});
		d.push_back('{-7, 50, -7, 90});
		d.push_back('{-100, 60, 900, 60});
		d.push_back('{900, 60, 100, 60});
		d.push_back('{-100, -100, 900, 700});
		d.push_back('{100, 100, 900, 700});
		d.push_back('{900, 700, 100, 100});
		d.push_back('{-10, 5, 5, -10});
		d.push_back('{-1, 0, 0, -1});
		d.push_back('{mn, mn, mx, mx});
		d.push_back('{mx, mn, mn, mx});
		d.push_back('{mn, 10, mx, 20});
		d.push_back('{-50, 900, 900, -50});
		d.push_back('{20, 20, -1000, 700});
		d.push_back('{mn, mx, 0, 0});
		foreach (d[i]) send_segment(d[i]);
		drain();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) send_segment(rand_segment());
	endtask

	task automatic test_screen_sizes();
		set_screen(15'd1, 15'd1);
		test_random(60);
		set_screen(15'h7fff, 15'h7fff);
		test_random(60);
		set_screen(15'd0, 15'd5);
		test_random(30);
		set_screen(15'd17, 15'd0);
		test_random(30);
		set_screen(15'h5555, 15'h2aaa);
		test_random(60);
		set_screen(15'h2aaa, 15'h5555);
		test_random(60);
		set_screen(15'd64, 15'd48);
		test_directed();
	endtask

	task automatic test_pause();
		test_random(50);
		drain();
		test_random(50);
	endtask

	task automatic test_no_idle();
		set_screen(WIDTH_RST, HEIGHT_RST);
		no_idle = 1'b1;
		test_random(350);
	endtask

	// result sink with random stall bursts
	always @(posedge clk) begin
		if (!no_idle && sink_hold == 0 && $urandom_range(0, 4) == 0) begin
			sink_hold <= $urandom_range(1, 13);
			res_out.ready <= 1'b0;
		end else if (sink_hold > 1 && !no_idle) begin
			sink_hold <= sink_hold - 1;
			res_out.ready <= 1'b0;
		end else begin
			sink_hold <= 0;
			res_out.ready <= arst_n;
		end
	end

	always @(posedge clk) begin
		clip_t e;
		if (arst_n && res_out.valid && res_out.ready) begin
			if (clip_q.size() == 0) begin
				$error("result transfer with nothing expected");
				fails++;
			end else begin
				e = clip_q.pop_front();
				if (res_out.rejected !== e.rej) begin
					$error("rejected exp %0d got %0d", e.rej, res_out.rejected); fails++;
				end
				if (res_out.clip_start_x !== e.csx) begin
					$error("clip_start_x exp %0d got %0d", e.csx, res_out.clip_start_x); fails++;
				end
				if (res_out.clip_start_y !== e.csy) begin
					$error("clip_start_y exp %0d got %0d", e.csy, res_out.clip_start_y); fails++;
				end
				if (res_out.clip_end_x !== e.cex) begin
					$error("clip_end_x exp %0d got %0d", e.cex, res_out.clip_end_x); fails++;
				end
				if (res_out.clip_end_y !== e.cey) begin
					$error("clip_end_y exp %0d got %0d", e.cey, res_out.clip_end_y); fails++;
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pause();
		test_screen_sizes();
		test_no_idle();
		drain();
		if (fails == 0 && clip_q.size() == 0) $display("tb OK");
		else $display("tb NOT OK");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb NOT OK");
		$finish;
	end
endmodule

`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/lssc_pkg.sv
hw/rtl/lssc_if.sv
hw/rtl/lssc_div.sv
hw/rtl/lssc_cfg.sv
hw/rtl/line_segment_screen_clipper_core.sv
dv/tb.sv
